FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/dps_pkg.sv
// ---------------------------------------------------------------------------
// dps_pkg
// shared codes, constants and types of the dock power sequencer
// ---------------------------------------------------------------------------
package dps_pkg;

  // sequencer states
  localparam logic [2:0] SEQ_RESET  = 3'd0;
  localparam logic [2:0] SEQ_IDLE   = 3'd1;
  localparam logic [2:0] SEQ_DETECT = 3'd2;
  localparam logic [2:0] SEQ_LOCK   = 3'd3;
  localparam logic [2:0] SEQ_OFF    = 3'd4;
  localparam logic [2:0] SEQ_ON     = 3'd5;

  // event commands
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_ADDR_WRITE = 3'd1;
  localparam logic [2:0] CMD_ADDR_READ  = 3'd2;
  localparam logic [2:0] CMD_RX_BYTE    = 3'd3;
  localparam logic [2:0] CMD_TX_DONE    = 3'd4;
  localparam logic [2:0] CMD_BUS_ERROR  = 3'd5;

  // bus command bytes and replies
  localparam logic [7:0] BUS_WRITE_REG   = 8'hA0;
  localparam logic [7:0] BUS_READ_ID     = 8'hA1;
  localparam logic [7:0] BUS_READ_GATE   = 8'hA2;
  localparam logic [7:0] BUS_READ_STATUS = 8'hA3;
  localparam logic [7:0] REPLY_ID        = 8'hDC;
  localparam logic [7:0] GATE_CLOSED     = 8'hFF;
  localparam logic [7:0] GATE_REG        = 8'd1;

  // configuration register indexes
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_PG_DELAY = 1'b1;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [15:0] PG_DELAY_RESET = 16'd1000;

  // side effects of a sequencer move on bus-owned state
  typedef struct packed {
    logic irq_set;
    logic gate_set;
  } seq_evt_t;

endpackage

FILE: hw/rtl/dps_if.sv
// ---------------------------------------------------------------------------
// dps_in_if / dps_out_if
// valid/ready channels carrying dock events and result items
// ---------------------------------------------------------------------------
interface dps_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] rx_byte;
  logic       lock_level;
  logic       detect_level;
  logic       enable_level;

  modport source (output valid, command, rx_byte, lock_level, detect_level,
                  enable_level, input ready);
  modport sink (input valid, command, rx_byte, lock_level, detect_level,
                enable_level, output ready);
endinterface

interface dps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] fsm_state;
  logic       white_led;
  logic       red_led;
  logic       case_led;
  logic       psu_on;
  logic       lock_detect;
  logic       host_irq;
  logic       rails_on;
  logic       power_good;
  logic       fans_on;
  logic       tx_valid;
  logic [7:0] tx_byte;

  modport source (output valid, fsm_state, white_led, red_led, case_led, psu_on,
                  lock_detect, host_irq, rails_on, power_good, fans_on, tx_valid,
                  tx_byte, input ready);
  modport sink (input valid, fsm_state, white_led, red_led, case_led, psu_on,
                lock_detect, host_irq, rails_on, power_good, fans_on, tx_valid,
                tx_byte, output ready);
endinterface

FILE: hw/rtl/dps_seq.sv
// ---------------------------------------------------------------------------
// dps_seq
// pin debounce, power-good delay and six-state power sequencer
// ---------------------------------------------------------------------------
module dps_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              lock_level,
  input  logic              detect_level,
  input  logic              enable_level,
  input  logic [15:0]       debounce_ticks,
  input  logic [15:0]       power_good_delay,
  input  logic [7:0]        host_gate,
  output logic [2:0]        state,
  output logic [2:0]        state_nxt,
  output logic              good_nxt,
  output dps_pkg::seq_evt_t evt
);

  logic [2:0]  state_r;
  logic        locked_r, locked_nxt;
  logic        present_r, present_nxt;
  logic        enable_r, enable_nxt;
  logic [15:0] quiet_r, quiet_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [1:0]  last_raw_r, last_raw_nxt;
  logic [15:0] good_cnt_r, good_cnt_nxt;
  logic        good_r;
  logic [1:0]  raw;
  logic [2:0]  target;
  logic        gate_open;

  assign raw       = {detect_level, lock_level};
  assign gate_open = (host_gate == 8'd0);

  always_comb begin
    locked_nxt   = locked_r;
    present_nxt  = present_r;
    enable_nxt   = enable_r;
    quiet_nxt    = quiet_r;
    pending_nxt  = pending_r;
    last_raw_nxt = last_raw_r;
    good_cnt_nxt = good_cnt_r;
    good_nxt     = good_r;
    state_nxt    = state_r;
    target       = state_r;
    evt          = '0;

    if (step) begin
      // debounce: reset state takes pins directly
      priority if (state_r == dps_pkg::SEQ_RESET) begin
        locked_nxt   = lock_level;
        present_nxt  = detect_level;
        last_raw_nxt = raw;
        pending_nxt  = 2'b00;
        quiet_nxt    = 16'd0;
      end else if (raw != last_raw_r) begin
        pending_nxt  = pending_r | (raw ^ last_raw_r);
        last_raw_nxt = raw;
        quiet_nxt    = debounce_ticks;
      end else if (pending_r != 2'b00) begin
        if (quiet_r <= 16'd1) begin
          if (pending_r[0]) locked_nxt = lock_level;
          if (pending_r[1]) present_nxt = detect_level;
          pending_nxt = 2'b00;
          quiet_nxt   = 16'd0;
        end else begin
          quiet_nxt = quiet_r - 16'd1;
        end
      end else begin
        // pins steady and settled
        pending_nxt = pending_r;
      end
      enable_nxt = enable_level;

      if (state_r == dps_pkg::SEQ_ON && !good_r) begin
        if (good_cnt_r != 16'd0) good_cnt_nxt = good_cnt_r - 16'd1;
        if (good_cnt_nxt == 16'd0) good_nxt = 1'b1;
      end

      unique case (state_r)
        dps_pkg::SEQ_RESET: target = dps_pkg::SEQ_IDLE;
        dps_pkg::SEQ_IDLE: begin
          if (gate_open) target = dps_pkg::SEQ_DETECT;
        end
        dps_pkg::SEQ_DETECT: begin
          priority if (!gate_open) target = dps_pkg::SEQ_IDLE;
          else if (present_nxt)    target = dps_pkg::SEQ_LOCK;
          else                     target = state_r;
        end
        dps_pkg::SEQ_LOCK: begin
          priority if (!gate_open) target = dps_pkg::SEQ_IDLE;
          else if (!present_nxt)   target = dps_pkg::SEQ_DETECT;
          else if (locked_nxt)     target = dps_pkg::SEQ_OFF;
          else                     target = state_r;
        end
        dps_pkg::SEQ_OFF: begin
          priority if (!gate_open) target = dps_pkg::SEQ_IDLE;
          else if (!present_nxt)   target = dps_pkg::SEQ_DETECT;
          else if (!locked_nxt)    target = dps_pkg::SEQ_LOCK;
          else if (enable_nxt)     target = dps_pkg::SEQ_ON;
          else                     target = state_r;
        end
        dps_pkg::SEQ_ON: begin
          priority if (!gate_open) target = dps_pkg::SEQ_IDLE;
          else if (!present_nxt)   target = dps_pkg::SEQ_DETECT;
          else if (!locked_nxt)    target = dps_pkg::SEQ_LOCK;
          else if (!enable_nxt)    target = dps_pkg::SEQ_OFF;
          else                     target = state_r;
        end
        default: target = dps_pkg::SEQ_RESET;
      endcase

      if (target != state_r) begin
        evt.irq_set  = (state_r < dps_pkg::SEQ_LOCK) && (target >= dps_pkg::SEQ_LOCK);
        evt.gate_set = (state_r == dps_pkg::SEQ_RESET) ||
                       ((state_r > dps_pkg::SEQ_DETECT) && (target <= dps_pkg::SEQ_DETECT));
        if (target == dps_pkg::SEQ_ON) begin
          good_cnt_nxt = power_good_delay;
          good_nxt     = (power_good_delay == 16'd0);
        end else begin
          good_cnt_nxt = 16'd0;
          good_nxt     = 1'b0;
        end
        state_nxt = target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dps_pkg::SEQ_RESET;
      locked_r   <= 1'b0;
      present_r  <= 1'b0;
      enable_r   <= 1'b0;
      quiet_r    <= 16'd0;
      pending_r  <= 2'b00;
      last_raw_r <= 2'b00;
      good_cnt_r <= 16'd0;
      good_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      locked_r   <= locked_nxt;
      present_r  <= present_nxt;
      enable_r   <= enable_nxt;
      quiet_r    <= quiet_nxt;
      pending_r  <= pending_nxt;
      last_raw_r <= last_raw_nxt;
      good_cnt_r <= good_cnt_nxt;
      good_r     <= good_nxt;
    end
  end

  assign state = state_r;

endmodule

FILE: hw/rtl/dps_bus.sv
// ---------------------------------------------------------------------------
// dps_bus
// byte-wise i2c slave parser, host gate byte, interrupt flag, reply register
// ---------------------------------------------------------------------------
module dps_bus (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [2:0]        command,
  input  logic [7:0]        rx_byte,
  input  dps_pkg::seq_evt_t evt,
  output logic [7:0]        host_gate,
  output logic              irq_nxt,
  output logic              tx_valid,
  output logic [7:0]        tx_byte
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_REG  = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SEND = 3'd4;
  localparam logic [2:0] PH_ACK  = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] reply_r, reply_nxt;
  logic [7:0] gate_r, gate_nxt;
  logic       irq_r;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    reg_nxt   = reg_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    reply_nxt = reply_r;
    gate_nxt  = gate_r;
    irq_nxt   = irq_r;
    tx_valid  = 1'b0;
    tx_byte   = 8'd0;

    // sequencer moves only happen on ticks, never together with bus bytes
    if (evt.gate_set) gate_nxt = dps_pkg::GATE_CLOSED;
    if (evt.irq_set)  irq_nxt = 1'b1;

    if (step) begin
      unique case (command)
        dps_pkg::CMD_ADDR_WRITE,
        dps_pkg::CMD_TX_DONE,
        dps_pkg::CMD_BUS_ERROR: phase_nxt = PH_IDLE;
        dps_pkg::CMD_ADDR_READ: begin
          if (phase_r == PH_SEND) begin
            phase_nxt = PH_ACK;
            tx_valid  = 1'b1;
            tx_byte   = reply_r;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        dps_pkg::CMD_RX_BYTE: begin
          unique case (phase_r)
            PH_IDLE: begin
              cmd_nxt = rx_byte;
              priority if (rx_byte == dps_pkg::BUS_WRITE_REG) begin
                phase_nxt = PH_REG;
              end else if (rx_byte == dps_pkg::BUS_READ_ID ||
                           rx_byte == dps_pkg::BUS_READ_GATE ||
                           rx_byte == dps_pkg::BUS_READ_STATUS) begin
                reg_nxt = 8'd0;
                priority if (rx_byte == dps_pkg::BUS_READ_ID) begin
                  irq_nxt   = 1'b0;
                  reply_nxt = dps_pkg::REPLY_ID;
                end else if (rx_byte == dps_pkg::BUS_READ_GATE) begin
                  reply_nxt = (gate_r == 8'd0) ? 8'd2 : 8'd1;
                end else begin
                  reply_nxt = 8'd1;
                end
                len_nxt   = 8'd1;
                phase_nxt = PH_SEND;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_REG: begin
              reg_nxt   = rx_byte;
              phase_nxt = PH_SIZE;
            end
            PH_SIZE: begin
              len_nxt   = rx_byte;
              seen_nxt  = 8'd0;
              phase_nxt = (rx_byte == 8'd0) ? PH_IDLE : PH_DATA;
            end
            PH_DATA: begin
              seen_nxt = seen_r + 8'd1;
              // only a single-byte write to the gate register lands
              if (seen_nxt == 8'd1 && len_r == 8'd1 && reg_r == dps_pkg::GATE_REG &&
                  cmd_r == dps_pkg::BUS_WRITE_REG)
                gate_nxt = rx_byte;
              if (seen_nxt >= len_r) phase_nxt = PH_IDLE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= 8'd0;
      reg_r   <= 8'd0;
      len_r   <= 8'd0;
      seen_r  <= 8'd0;
      reply_r <= 8'd0;
      gate_r  <= dps_pkg::GATE_CLOSED;
      irq_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      reg_r   <= reg_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      reply_r <= reply_nxt;
      gate_r  <= gate_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign host_gate = gate_r;

endmodule

FILE: hw/rtl/dock_power_sequencer_i2c_slave_unit.sv
// ---------------------------------------------------------------------------
// dock_power_sequencer_i2c_slave_unit
// Dock power sequencer with an i2c slave front end. Every accepted item is
// one event (a pin tick or an i2c bus event) and yields exactly one result
// item with the dock outputs after that event. An item is registered at the
// input, then processed into the output register. One item is taken every
// cycle; the only limit on rate is the output register draining, which the
// input stage follows without a bubble. The configuration registers
// (debounce ticks, power-good delay) are written through the cfg port; the
// user must do so only while the block idles; the block does not check it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dock_power_sequencer_i2c_slave_unit (
  input  logic        clk,
  input  logic        rst_n,
  dps_in_if.sink      in_ch,
  dps_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] debounce_r;
  logic [15:0] pg_delay_r;

  logic       s1_valid_r;
  logic [2:0] s1_cmd_r;
  logic [7:0] s1_rx_r;
  logic       s1_lock_r;
  logic       s1_detect_r;
  logic       s1_enable_r;
  logic       adv;
  logic       tick_step;

  logic [2:0]        seq_state;
  logic [2:0]        state_nxt;
  logic              good_nxt;
  dps_pkg::seq_evt_t evt;
  logic [7:0]        host_gate;
  logic              irq_nxt;
  logic              tx_valid;
  logic [7:0]        tx_byte;

  logic       out_valid_r;
  logic [2:0] out_state_r;
  logic       out_irq_r;
  logic       out_good_r;
  logic       out_txv_r;
  logic [7:0] out_txb_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= dps_pkg::DEBOUNCE_RESET;
      pg_delay_r <= dps_pkg::PG_DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dps_pkg::CFG_DEBOUNCE: debounce_r <= cfg_wdata;
        dps_pkg::CFG_PG_DELAY: pg_delay_r <= cfg_wdata;
      endcase
    end
  end

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign tick_step   = adv && (s1_cmd_r == dps_pkg::CMD_TICK);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r    <= in_ch.command;
      s1_rx_r     <= in_ch.rx_byte;
      s1_lock_r   <= in_ch.lock_level;
      s1_detect_r <= in_ch.detect_level;
      s1_enable_r <= in_ch.enable_level;
    end
  end

  dps_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (tick_step),
    .lock_level       (s1_lock_r),
    .detect_level     (s1_detect_r),
    .enable_level     (s1_enable_r),
    .debounce_ticks   (debounce_r),
    .power_good_delay (pg_delay_r),
    .host_gate        (host_gate),
    .state            (seq_state),
    .state_nxt        (state_nxt),
    .good_nxt         (good_nxt),
    .evt              (evt)
  );

  dps_bus u_bus (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .command   (s1_cmd_r),
    .rx_byte   (s1_rx_r),
    .evt       (evt),
    .host_gate (host_gate),
    .irq_nxt   (irq_nxt),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_state_r <= state_nxt;
      out_irq_r   <= irq_nxt;
      out_good_r  <= good_nxt;
      out_txv_r   <= tx_valid;
      out_txb_r   <= tx_byte;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.fsm_state   = out_state_r;
  assign out_ch.white_led   = (out_state_r == dps_pkg::SEQ_LOCK) ||
                              (out_state_r == dps_pkg::SEQ_OFF);
  assign out_ch.red_led     = (out_state_r == dps_pkg::SEQ_ON);
  assign out_ch.case_led    = (out_state_r == dps_pkg::SEQ_ON);
  assign out_ch.psu_on      = (out_state_r >= dps_pkg::SEQ_LOCK);
  assign out_ch.lock_detect = (out_state_r >= dps_pkg::SEQ_OFF);
  assign out_ch.host_irq    = out_irq_r;
  assign out_ch.rails_on    = (out_state_r == dps_pkg::SEQ_ON);
  assign out_ch.power_good  = out_good_r;
  assign out_ch.fans_on     = (out_state_r == dps_pkg::SEQ_ON);
  assign out_ch.tx_valid    = out_txv_r;
  assign out_ch.tx_byte     = out_txb_r;

  // a reply byte only comes from an address read
  `ASSERT_NEXT(a_txv_only_read, clk, rst_n,
    adv && (s1_cmd_r != dps_pkg::CMD_ADDR_READ), !out_txv_r)
  // power good is never reported outside the power-on state
  `ASSERT_ALWAYS(a_good_in_on, clk, rst_n,
    !out_valid_r || !out_good_r || (out_state_r == dps_pkg::SEQ_ON))
  // the sequencer moves only on an accepted tick
  `ASSERT_NEXT(a_state_on_tick, clk, rst_n, !tick_step, $stable(seq_state))

endmodule

FILE: sim/tb_dock_power_sequencer_i2c_slave_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dock_power_sequencer_i2c_slave_unit
// Self-checking bench for the dock power sequencer. A directed table comes
// first. It covers reset, stray reads, unknown bus bytes, gate writes, the
// climb to power-on and the reply bytes. After it come random pin runs and
// i2c transactions under several debounce and power-good settings. Every
// event is predicted in the bench and compared field by field on the
// result channel. Both sides idle at random, and once the result side
// holds off long enough for the block to back up.
// ---------------------------------------------------------------------------
module tb_dock_power_sequencer_i2c_slave_unit;

  // i2c slave parse phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_REG  = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SEND = 3'd4;
  localparam logic [2:0] PH_ACK  = 3'd5;

  localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
  localparam logic [2:0] CMD_RESERVED_7 = 3'd7;
  localparam logic [7:0] BUS_UNKNOWN    = 8'hE6;
  localparam logic [7:0] REPLY_OPEN     = 8'd2;
  localparam logic [7:0] REPLY_SHUT     = 8'd1;
  localparam logic [7:0] REPLY_STATUS   = 8'd1;
  localparam logic [7:0] GATE_OPEN      = 8'h00;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int LONG_HOLD       = 200;
  localparam int HOLD_AT_RESULT  = 700;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] rx_byte;
    logic       lock_level;
    logic       detect_level;
    logic       enable_level;
  } dock_event_t;

  typedef struct packed {
    logic [2:0] fsm_state;
    logic       white_led;
    logic       red_led;
    logic       case_led;
    logic       psu_on;
    logic       lock_detect;
    logic       host_irq;
    logic       rails_on;
    logic       power_good;
    logic       fans_on;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } dock_result_t;

  typedef struct packed {
    dock_event_t  ev;
    logic         has_want;
    dock_result_t want;
  } dock_row_t;

  localparam dock_result_t IDLE_QUIET = '{dps_pkg::SEQ_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};

  // bring-up walk: debounce 1, power-good delay 0
  localparam dock_row_t DIRECTED_ROWS [27] = '{
    '{'{dps_pkg::CMD_TICK,       8'h00,                    1'b1, 1'b1, 1'b0}, 1'b1,
      IDLE_QUIET},
    '{'{dps_pkg::CMD_ADDR_READ,  8'h00,                    1'b0, 1'b0, 1'b0}, 1'b1,
      IDLE_QUIET},
    '{'{CMD_RESERVED_7,          8'hFF,                    1'b1, 1'b1, 1'b1}, 1'b1,
      IDLE_QUIET},
    '{'{dps_pkg::CMD_RX_BYTE,    BUS_UNKNOWN,              1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    dps_pkg::BUS_WRITE_REG,   1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    8'h05,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    dps_pkg::BUS_WRITE_REG,   1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    dps_pkg::GATE_REG,        1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    8'h01,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    GATE_OPEN,                1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_TICK,       8'h00,                    1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{dps_pkg::CMD_TICK,       8'h00,                    1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{dps_pkg::CMD_TICK,       8'h00,                    1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{dps_pkg::CMD_TICK,       8'h00,                    1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{dps_pkg::CMD_ADDR_WRITE, 8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    dps_pkg::BUS_READ_ID,     1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_ADDR_READ,  8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    8'hFF,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_BUS_ERROR,  8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    dps_pkg::BUS_READ_GATE,   1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_ADDR_READ,  8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_TX_DONE,    8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_RX_BYTE,    dps_pkg::BUS_READ_STATUS, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_ADDR_READ,  8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_TICK,       8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{dps_pkg::CMD_TICK,       8'h00,                    1'b0, 1'b0, 1'b0}, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  dps_in_if  in_ch ();
  dps_out_if out_ch ();

  dock_power_sequencer_i2c_slave_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predicted copy of the block state
  logic [15:0] p_debounce, p_pg_delay;
  logic [2:0]  p_state, p_phase;
  logic [7:0]  p_bus_cmd, p_bus_reg, p_bus_len, p_seen, p_reply, p_gate;
  logic        p_irq, p_locked, p_present, p_enable, p_good_flag;
  logic [15:0] p_quiet, p_good_cnt;
  logic [1:0]  p_pending, p_last_raw;

  dock_result_t outputs_due [$];

  logic pin_lock, pin_detect, pin_enable;
  int   items_sent, offers, results_seen, mismatches, replies_seen, power_good_seen;
  int   settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[dock_power_sequencer_i2c_slave_unit] ERROR");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic dock_event_t bus_event(input logic [2:0] cmd, input logic [7:0] b);
    logic [2:0] pins;
    pins = 3'($urandom);
    return '{cmd, b, pins[0], pins[1], pins[2]};
  endfunction

  function automatic dock_event_t pin_tick();
    return '{dps_pkg::CMD_TICK, rand_byte(), pin_lock, pin_detect, pin_enable};
  endfunction

  task automatic predict_dock_outputs(input dock_event_t ev, output dock_result_t res);
    logic [1:0] raw;
    logic [2:0] s, nxt;
    logic       tx_v;
    logic [7:0] tx_b, b;
    raw  = {ev.detect_level, ev.lock_level};
    b    = ev.rx_byte;
    tx_v = 1'b0;
    tx_b = 8'h00;
    case (ev.command)
      dps_pkg::CMD_TICK: begin
        s   = p_state;
        nxt = s;
        if (s == dps_pkg::SEQ_RESET) begin
          // pins are taken straight, no debounce
          p_locked   = ev.lock_level;
          p_present  = ev.detect_level;
          p_last_raw = raw;
          p_pending  = 2'b00;
          p_quiet    = 16'd0;
        end else if (raw != p_last_raw) begin
          p_pending  = p_pending | (raw ^ p_last_raw);
          p_last_raw = raw;
          p_quiet    = p_debounce;
        end else if (p_pending != 2'b00) begin
          if (p_quiet <= 16'd1) begin
            if (p_pending[0]) p_locked = ev.lock_level;
            if (p_pending[1]) p_present = ev.detect_level;
            p_pending = 2'b00;
            p_quiet   = 16'd0;
          end else begin
            p_quiet = p_quiet - 16'd1;
          end
        end
        p_enable = ev.enable_level;
        if (s == dps_pkg::SEQ_ON && !p_good_flag) begin
          if (p_good_cnt != 16'd0) p_good_cnt = p_good_cnt - 16'd1;
          if (p_good_cnt == 16'd0) p_good_flag = 1'b1;
        end
        case (s)
          dps_pkg::SEQ_RESET: nxt = dps_pkg::SEQ_IDLE;
          dps_pkg::SEQ_IDLE: begin
            if (p_gate == GATE_OPEN) nxt = dps_pkg::SEQ_DETECT;
          end
          dps_pkg::SEQ_DETECT: begin
            if (p_gate != GATE_OPEN) nxt = dps_pkg::SEQ_IDLE;
            else if (p_present) nxt = dps_pkg::SEQ_LOCK;
          end
          dps_pkg::SEQ_LOCK: begin
            if (p_gate != GATE_OPEN) nxt = dps_pkg::SEQ_IDLE;
            else if (!p_present) nxt = dps_pkg::SEQ_DETECT;
            else if (p_locked) nxt = dps_pkg::SEQ_OFF;
          end
          dps_pkg::SEQ_OFF: begin
            if (p_gate != GATE_OPEN) nxt = dps_pkg::SEQ_IDLE;
            else if (!p_present) nxt = dps_pkg::SEQ_DETECT;
            else if (!p_locked) nxt = dps_pkg::SEQ_LOCK;
            else if (p_enable) nxt = dps_pkg::SEQ_ON;
          end
          dps_pkg::SEQ_ON: begin
            if (p_gate != GATE_OPEN) nxt = dps_pkg::SEQ_IDLE;
            else if (!p_present) nxt = dps_pkg::SEQ_DETECT;
            else if (!p_locked) nxt = dps_pkg::SEQ_LOCK;
            else if (!p_enable) nxt = dps_pkg::SEQ_OFF;
          end
          default: nxt = dps_pkg::SEQ_RESET;
        endcase
        if (nxt != s) begin
          if (s < dps_pkg::SEQ_LOCK && nxt >= dps_pkg::SEQ_LOCK) p_irq = 1'b1;
          // leaving reset or dropping below lock shuts the gate again
          if (s == dps_pkg::SEQ_RESET ||
              (s > dps_pkg::SEQ_DETECT && nxt <= dps_pkg::SEQ_DETECT))
            p_gate = dps_pkg::GATE_CLOSED;
          if (nxt == dps_pkg::SEQ_ON) begin
            p_good_cnt  = p_pg_delay;
            p_good_flag = (p_pg_delay == 16'd0);
          end else begin
            p_good_cnt  = 16'd0;
            p_good_flag = 1'b0;
          end
          p_state = nxt;
        end
      end
      dps_pkg::CMD_ADDR_WRITE, dps_pkg::CMD_TX_DONE, dps_pkg::CMD_BUS_ERROR:
        p_phase = PH_IDLE;
      dps_pkg::CMD_ADDR_READ: begin
        if (p_phase == PH_SEND) begin
          p_phase = PH_ACK;
          tx_v    = 1'b1;
          tx_b    = p_reply;
        end else begin
          p_phase = PH_IDLE;
        end
      end
      dps_pkg::CMD_RX_BYTE: begin
        case (p_phase)
          PH_IDLE: begin
            p_bus_cmd = b;
            if (b == dps_pkg::BUS_WRITE_REG) begin
              p_phase = PH_REG;
            end else if (b == dps_pkg::BUS_READ_ID || b == dps_pkg::BUS_READ_GATE ||
                         b == dps_pkg::BUS_READ_STATUS) begin
              p_bus_reg = 8'h00;
              if (b == dps_pkg::BUS_READ_ID) begin
                p_irq   = 1'b0;
                p_reply = dps_pkg::REPLY_ID;
              end else if (b == dps_pkg::BUS_READ_GATE) begin
                p_reply = (p_gate == GATE_OPEN) ? REPLY_OPEN : REPLY_SHUT;
              end else begin
                p_reply = REPLY_STATUS;
              end
              p_bus_len = 8'd1;
              p_phase   = PH_SEND;
            end else begin
              p_phase = PH_IDLE;
            end
          end
          PH_REG: begin
            p_bus_reg = b;
            p_phase   = PH_SIZE;
          end
          PH_SIZE: begin
            p_bus_len = b;
            p_seen    = 8'd0;
            p_phase   = (b == 8'd0) ? PH_IDLE : PH_DATA;
          end
          PH_DATA: begin
            p_seen = p_seen + 8'd1;
            if (p_seen == 8'd1 && p_bus_len == 8'd1 && p_bus_reg == dps_pkg::GATE_REG &&
                p_bus_cmd == dps_pkg::BUS_WRITE_REG)
              p_gate = b;
            if (p_seen >= p_bus_len) p_phase = PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.fsm_state   = p_state;
    res.white_led   = (p_state == dps_pkg::SEQ_LOCK || p_state == dps_pkg::SEQ_OFF);
    res.red_led     = (p_state == dps_pkg::SEQ_ON);
    res.case_led    = (p_state == dps_pkg::SEQ_ON);
    res.psu_on      = (p_state >= dps_pkg::SEQ_LOCK);
    res.lock_detect = (p_state >= dps_pkg::SEQ_OFF);
    res.host_irq    = p_irq;
    res.rails_on    = (p_state == dps_pkg::SEQ_ON);
    res.power_good  = p_good_flag;
    res.fans_on     = (p_state == dps_pkg::SEQ_ON);
    res.tx_valid    = tx_v;
    res.tx_byte     = tx_b;
  endtask

  task automatic offer_event(input dock_event_t ev, input logic has_want,
                             input dock_result_t want);
    int           gap;
    dock_result_t res;
    gap = (offers % 160 < 32) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= ev.command;
    in_ch.rx_byte      <= ev.rx_byte;
    in_ch.lock_level   <= ev.lock_level;
    in_ch.detect_level <= ev.detect_level;
    in_ch.enable_level <= ev.enable_level;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_dock_outputs(ev, res);
    outputs_due.push_back(has_want ? want : res);
    offers++;
    if (ev.command <= dps_pkg::CMD_BUS_ERROR) items_sent++;
  endtask

  task automatic drain_dock_outputs();
    in_ch.valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_dock_settings(input logic [15:0] debounce, input logic [15:0] pg_delay);
    cfg_we    <= 1'b1;
    cfg_index <= dps_pkg::CFG_DEBOUNCE;
    cfg_wdata <= debounce;
    @(posedge clk);
    cfg_index <= dps_pkg::CFG_PG_DELAY;
    cfg_wdata <= pg_delay;
    @(posedge clk);
    cfg_we     <= 1'b0;
    p_debounce  = debounce;
    p_pg_delay  = pg_delay;
    settings_used++;
  endtask

  task automatic run_dock_scenario();
    int         kind, n;
    logic [7:0] sz, b;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // run of ticks, pins mostly steady so the debounce settles
      if ($urandom_range(0, 3) == 0) begin
        pin_lock   = ($urandom_range(0, 4) != 0);
        pin_detect = ($urandom_range(0, 4) != 0);
        pin_enable = 1'($urandom_range(0, 1));
      end
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0) pin_lock = !pin_lock;
        if ($urandom_range(0, 19) == 0) pin_detect = !pin_detect;
        if ($urandom_range(0, 9) == 0) pin_enable = !pin_enable;
        offer_event(pin_tick(), 1'b0, '0);
      end
    end else if (kind < 55) begin
      // gate byte write, mostly opening it
      if ($urandom_range(0, 1) != 0)
        offer_event(bus_event(dps_pkg::CMD_ADDR_WRITE, rand_byte()), 1'b0, '0);
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, dps_pkg::BUS_WRITE_REG), 1'b0, '0);
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, dps_pkg::GATE_REG), 1'b0, '0);
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, 8'd1), 1'b0, '0);
      b = ($urandom_range(0, 3) != 0) ? GATE_OPEN : rand_byte();
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, b), 1'b0, '0);
      if ($urandom_range(0, 1) != 0)
        offer_event(bus_event(dps_pkg::CMD_TX_DONE, rand_byte()), 1'b0, '0);
    end else if (kind < 67) begin
      // read transaction
      offer_event(bus_event(dps_pkg::CMD_ADDR_WRITE, rand_byte()), 1'b0, '0);
      n = $urandom_range(0, 9);
      b = (n < 3) ? dps_pkg::BUS_READ_ID : (n < 6) ? dps_pkg::BUS_READ_GATE :
          (n < 9) ? dps_pkg::BUS_READ_STATUS : rand_byte();
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, b), 1'b0, '0);
      offer_event(bus_event(dps_pkg::CMD_ADDR_READ, rand_byte()), 1'b0, '0);
      if ($urandom_range(0, 4) == 0)
        offer_event(bus_event(dps_pkg::CMD_ADDR_READ, rand_byte()), 1'b0, '0);
      if ($urandom_range(0, 4) == 0)
        offer_event(bus_event(dps_pkg::CMD_RX_BYTE, rand_byte()), 1'b0, '0);
      offer_event(bus_event(($urandom_range(0, 1) != 0) ? dps_pkg::CMD_TX_DONE :
                            dps_pkg::CMD_BUS_ERROR, rand_byte()), 1'b0, '0);
    end else if (kind < 77) begin
      // register write of any size, dropped unless it is a single-byte gate write
      b  = ($urandom_range(0, 3) == 0) ? rand_byte() : 8'($urandom_range(0, 3));
      sz = ($urandom_range(0, 29) == 0) ? rand_byte() : 8'($urandom_range(0, 4));
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, dps_pkg::BUS_WRITE_REG), 1'b0, '0);
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, b), 1'b0, '0);
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, sz), 1'b0, '0);
      repeat (sz) offer_event(bus_event(dps_pkg::CMD_RX_BYTE, rand_byte()), 1'b0, '0);
    end else if (kind < 85) begin
      // write cut short by another bus event
      offer_event(bus_event(dps_pkg::CMD_RX_BYTE, dps_pkg::BUS_WRITE_REG), 1'b0, '0);
      n = $urandom_range(0, 2);
      repeat (n)
        offer_event(bus_event(dps_pkg::CMD_RX_BYTE, 8'($urandom_range(0, 2))), 1'b0, '0);
      offer_event(bus_event(3'($urandom_range(1, 5)), rand_byte()), 1'b0, '0);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) offer_event(bus_event(3'($urandom_range(0, 7)), rand_byte()), 1'b0, '0);
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      mismatches++;
    end
  endtask

  // result side
  initial begin
    int           stall;
    dock_result_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = (results_seen % 150 < 30) ? 0 : $urandom_range(0, 3);
      if (results_seen == HOLD_AT_RESULT) stall = LONG_HOLD;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      results_seen++;
      if (outputs_due.size() == 0) begin
        $error("result item with no event outstanding");
        mismatches++;
      end else begin
        want = outputs_due.pop_front();
        compare_field("fsm_state", 8'(want.fsm_state), 8'(out_ch.fsm_state));
        compare_field("white_led", 8'(want.white_led), 8'(out_ch.white_led));
        compare_field("red_led", 8'(want.red_led), 8'(out_ch.red_led));
        compare_field("case_led", 8'(want.case_led), 8'(out_ch.case_led));
        compare_field("psu_on", 8'(want.psu_on), 8'(out_ch.psu_on));
        compare_field("lock_detect", 8'(want.lock_detect), 8'(out_ch.lock_detect));
        compare_field("host_irq", 8'(want.host_irq), 8'(out_ch.host_irq));
        compare_field("rails_on", 8'(want.rails_on), 8'(out_ch.rails_on));
        compare_field("power_good", 8'(want.power_good), 8'(out_ch.power_good));
        compare_field("fans_on", 8'(want.fans_on), 8'(out_ch.fans_on));
        compare_field("tx_valid", 8'(want.tx_valid), 8'(out_ch.tx_valid));
        compare_field("tx_byte", want.tx_byte, out_ch.tx_byte);
        if (want.tx_valid) replies_seen++;
        if (want.power_good) power_good_seen++;
      end
    end
  end

  // event side
  initial begin
    int          phase_start;
    logic [15:0] deb, pgd;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= dps_pkg::CFG_DEBOUNCE;
    cfg_wdata          <= 16'd0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= dps_pkg::CMD_TICK;
    in_ch.rx_byte      <= 8'h00;
    in_ch.lock_level   <= 1'b0;
    in_ch.detect_level <= 1'b0;
    in_ch.enable_level <= 1'b0;
    p_debounce  = dps_pkg::DEBOUNCE_RESET;
    p_pg_delay  = dps_pkg::PG_DELAY_RESET;
    p_state     = dps_pkg::SEQ_RESET;
    p_phase     = PH_IDLE;
    p_bus_cmd   = 8'h00;
    p_bus_reg   = 8'h00;
    p_bus_len   = 8'h00;
    p_seen      = 8'h00;
    p_reply     = 8'h00;
    p_gate      = dps_pkg::GATE_CLOSED;
    p_irq       = 1'b0;
    p_locked    = 1'b0;
    p_present   = 1'b0;
    p_enable    = 1'b0;
    p_quiet     = 16'd0;
    p_pending   = 2'b00;
    p_last_raw  = 2'b00;
    p_good_cnt  = 16'd0;
    p_good_flag = 1'b0;
    pin_lock    = 1'b1;
    pin_detect  = 1'b1;
    pin_enable  = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    apply_dock_settings(16'd1, 16'd0);
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      offer_event(DIRECTED_ROWS[i].ev, DIRECTED_ROWS[i].has_want, DIRECTED_ROWS[i].want);
    drain_dock_outputs();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin deb = 16'd2; pgd = 16'd4; end
        1: begin deb = 16'd1; pgd = 16'd0; end
        2: begin deb = 16'hFFFF; pgd = 16'hFFFF; end
        3: begin deb = 16'd5; pgd = 16'd30; end
        4: begin deb = 16'd1; pgd = 16'hFFFF; end
        5: begin deb = 16'd3; pgd = 16'd1; end
        default: begin
          deb = 16'($urandom_range(1, 6));
          pgd = 16'($urandom_range(0, 40));
        end
      endcase
      apply_dock_settings(deb, pgd);
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) run_dock_scenario();
      drain_dock_outputs();
    end

    $display("%0d bus and pin events under %0d settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("%0d read replies and %0d power-good results seen", replies_seen,
             power_good_seen);
    if (mismatches == 0) begin
      $display("[dock_power_sequencer_i2c_slave_unit] OK");
    end else begin
      $display("[dock_power_sequencer_i2c_slave_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: dock_power_sequencer_i2c_slave_unit.f
+incdir+hw/rtl
hw/rtl/dps_pkg.sv
hw/rtl/dps_if.sv
hw/rtl/dps_seq.sv
hw/rtl/dps_bus.sv
hw/rtl/dock_power_sequencer_i2c_slave_unit.sv
sim/tb_dock_power_sequencer_i2c_slave_unit.sv
